/* hdl/mmpp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max peak pyramid package
// Shared widths, defaults, controller/datapath handshake types and the level
// threshold function used to derive the number of active levels.
// ----------------------------------------------------------------------------
package mmpp_pkg;

   localparam int RATIO_DEF          = 4;
   localparam int MAX_LEVELS_DEF     = 12;
   localparam int SMALLEST_LEVEL_DEF = 64;

   localparam int COUNT_W  = 24;
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 4;
   localparam int INDEX_W  = 22;
   localparam int THRESH_W = COUNT_W + 1;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic flush;
      logic final_item;
   } mmpp_cmd_type;

   typedef struct packed {
      logic emit;
      logic pend_valid;
      logic step_ready;
      logic flush_ready;
   } mmpp_status_type;

   // Smallest base count for which the level with this number exists, less
   // one. Saturates above the largest base count so the compare stays false.
   function automatic logic [THRESH_W-1:0] level_threshold(input int smallest,
                                                          input int ratio,
                                                          input int lvl);
      longint t;
      longint cap;
      t   = longint'(smallest);
      cap = longint'(1) << COUNT_W;
      for (int i = 0; i < lvl; i++) begin
         t = t * longint'(ratio);
         if (t > cap) begin
            t = cap;
         end
      end
      return THRESH_W'(t);
   endfunction

endpackage
`default_nettype wire

/* hdl/mmpp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max peak pyramid datapath
// Per-level group stores and counters, the carry word that climbs the levels,
// one pending result and the result output register.
// ----------------------------------------------------------------------------
module mmpp_datapath
   import mmpp_pkg::*;
#(
   parameter int RATIO      = RATIO_DEF,
   parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mmpp_cmd_type               cmd,
   input  wire logic [((MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1)-1:0] lvl,
   output mmpp_status_type                 status,
   input  wire logic signed [SAMPLE_W-1:0] in_low,
   input  wire logic signed [SAMPLE_W-1:0] in_high,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [LEVEL_W-1:0]              rsp_level,
   output logic [INDEX_W-1:0]              rsp_bucket_index,
   output logic signed [SAMPLE_W-1:0]      rsp_peak_low,
   output logic signed [SAMPLE_W-1:0]      rsp_peak_high,
   output logic                            rsp_level_end,
   output logic                            rsp_run_end
);

   localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int FILL_W = $clog2(RATIO + 1);

   logic [FILL_W-1:0]          fill_ff    [MAX_LEVELS];
   logic [INDEX_W-1:0]         written_ff [MAX_LEVELS];
   logic signed [SAMPLE_W-1:0] group_low_ff  [MAX_LEVELS];
   logic signed [SAMPLE_W-1:0] group_high_ff [MAX_LEVELS];

   logic                       carry_ff;
   logic signed [SAMPLE_W-1:0] carry_low_ff;
   logic signed [SAMPLE_W-1:0] carry_high_ff;

   logic                       pend_valid_ff;
   logic [LEVEL_W-1:0]         pend_level_ff;
   logic [INDEX_W-1:0]         pend_index_ff;
   logic signed [SAMPLE_W-1:0] pend_low_ff;
   logic signed [SAMPLE_W-1:0] pend_high_ff;
   logic                       pend_end_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [LEVEL_W-1:0]         rsp_level_ff;
   logic [INDEX_W-1:0]         rsp_index_ff;
   logic signed [SAMPLE_W-1:0] rsp_low_ff;
   logic signed [SAMPLE_W-1:0] rsp_high_ff;
   logic                       rsp_level_end_ff;
   logic                       rsp_run_end_ff;

   logic [FILL_W-1:0]          fill_cur;
   logic [FILL_W-1:0]          fill_new;
   logic signed [SAMPLE_W-1:0] g_low;
   logic signed [SAMPLE_W-1:0] g_high;
   logic signed [SAMPLE_W-1:0] merged_low;
   logic signed [SAMPLE_W-1:0] merged_high;
   logic [IDX_W:0]             lvl_plus;
   logic                       emit;
   logic                       out_free;
   logic                       move_pend;
   logic                       move_flush;
   logic                       out_load;

   always_comb begin
      fill_cur = fill_ff[lvl];
      g_low    = group_low_ff[lvl];
      g_high   = group_high_ff[lvl];
      fill_new = fill_cur + FILL_W'(carry_ff);
      if (!carry_ff) begin
         merged_low  = g_low;
         merged_high = g_high;
      end else if (fill_cur == '0) begin
         merged_low  = carry_low_ff;
         merged_high = carry_high_ff;
      end else begin
         merged_low  = (carry_low_ff < g_low) ? carry_low_ff : g_low;
         merged_high = (carry_high_ff > g_high) ? carry_high_ff : g_high;
      end
      emit = (fill_new >= FILL_W'(RATIO)) || (cmd.final_item && (fill_new != '0));
      lvl_plus = {1'b0, lvl} + (IDX_W + 1)'(1);
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign move_pend    = cmd.step && emit && pend_valid_ff;
   assign move_flush   = cmd.flush && pend_valid_ff;
   assign out_load     = move_pend || move_flush;
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   assign status.emit        = emit;
   assign status.pend_valid  = pend_valid_ff;
   assign status.step_ready  = !(emit && pend_valid_ff && !out_free);
   assign status.flush_ready = !pend_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            fill_ff[i]    <= '0;
            written_ff[i] <= '0;
         end
         carry_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
               fill_ff[i]    <= '0;
               written_ff[i] <= '0;
            end
         end
         if (cmd.load) begin
            carry_ff <= 1'b1;
         end
         if (cmd.step) begin
            if (emit) begin
               fill_ff[lvl]    <= '0;
               written_ff[lvl] <= written_ff[lvl] + INDEX_W'(1);
               pend_valid_ff   <= 1'b1;
               carry_ff        <= 1'b1;
            end else begin
               fill_ff[lvl] <= fill_new;
               carry_ff     <= 1'b0;
            end
         end
         if (move_flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         carry_low_ff  <= in_low;
         carry_high_ff <= in_high;
      end
      if (cmd.step) begin
         if (emit) begin
            carry_low_ff  <= merged_low;
            carry_high_ff <= merged_high;
            pend_level_ff <= LEVEL_W'(lvl_plus);
            pend_index_ff <= written_ff[lvl];
            pend_low_ff   <= merged_low;
            pend_high_ff  <= merged_high;
            pend_end_ff   <= cmd.final_item;
         end else begin
            group_low_ff[lvl]  <= merged_low;
            group_high_ff[lvl] <= merged_high;
         end
      end
      if (out_load) begin
         rsp_level_ff     <= pend_level_ff;
         rsp_index_ff     <= pend_index_ff;
         rsp_low_ff       <= pend_low_ff;
         rsp_high_ff      <= pend_high_ff;
         rsp_level_end_ff <= pend_end_ff;
         rsp_run_end_ff   <= move_flush;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign rsp_peak_low     = rsp_low_ff;
   assign rsp_peak_high    = rsp_high_ff;
   assign rsp_level_end    = rsp_level_end_ff;
   assign rsp_run_end      = rsp_run_end_ff;

endmodule
`default_nettype wire

/* hdl/mmpp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max peak pyramid controller
// Holds the run configuration and item count, and walks the datapath through
// the levels of one word, then hands over its last result.
// ----------------------------------------------------------------------------
module mmpp_ctrl
   import mmpp_pkg::*;
#(
   parameter int RATIO          = RATIO_DEF,
   parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
   parameter int SMALLEST_LEVEL = SMALLEST_LEVEL_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output mmpp_cmd_type            cmd,
   output logic [((MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1)-1:0] lvl,
   input  wire mmpp_status_type    status
);

   localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CNT_W = $clog2(MAX_LEVELS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_STEP  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [COUNT_W-1:0] base_count_ff;
   logic [COUNT_W-1:0] items_seen_ff;
   logic [COUNT_W-1:0] items_seen_in;
   logic [CNT_W-1:0]   levels_active_ff;
   logic [CNT_W-1:0]   levels_active_in;
   logic [IDX_W-1:0]   lvl_ff;
   logic [IDX_W-1:0]   lvl_in;
   logic               final_ff;
   logic               final_in;
   logic               accept;
   logic               counted;
   logic [CNT_W-1:0]   lvl_next;
   logic               last_step;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign counted   = accept && (items_seen_ff < base_count_ff);
   assign lvl_next  = CNT_W'(lvl_ff) + CNT_W'(1);
   assign last_step = (lvl_next == levels_active_ff) || (!status.emit && !final_ff);

   always_comb begin
      levels_active_in = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if ({1'b0, csr_wr_data} > level_threshold(SMALLEST_LEVEL, RATIO, i)) begin
            levels_active_in = levels_active_in + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      items_seen_in  = items_seen_ff;
      lvl_in         = lvl_ff;
      final_in       = final_ff;
      cmd.clear      = csr_wr_en;
      cmd.load       = 1'b0;
      cmd.step       = 1'b0;
      cmd.flush      = 1'b0;
      cmd.final_item = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (counted) begin
               items_seen_in = items_seen_ff + COUNT_W'(1);
               final_in      = (items_seen_in == base_count_ff);
               lvl_in        = '0;
               if (levels_active_ff != '0) begin
                  cmd.load = 1'b1;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (status.step_ready) begin
               cmd.step = 1'b1;
               if (last_step) begin
                  state_in = ST_FLUSH;
               end else begin
                  lvl_in = IDX_W'(lvl_next);
               end
            end
         end
         ST_FLUSH: begin
            if (status.flush_ready) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         items_seen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         base_count_ff    <= '0;
         items_seen_ff    <= '0;
         levels_active_ff <= '0;
         lvl_ff           <= '0;
         final_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         items_seen_ff <= items_seen_in;
         lvl_ff        <= lvl_in;
         final_ff      <= final_in;
         if (csr_wr_en) begin
            base_count_ff    <= csr_wr_data;
            levels_active_ff <= levels_active_in;
         end
      end
   end

   assign lvl = lvl_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.pend_valid)
      else $error("Pending result left over after a word completed.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      items_seen_ff <= base_count_ff)
      else $error("Item count passed the configured base count.");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (CNT_W'(lvl_ff) < levels_active_ff))
      else $error("Level walk went past the active levels.");

   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && final_ff && lvl_ff == '0) |-> status.emit)
      else $error("Last base word did not close the lowest level.");

endmodule
`default_nettype wire

/* hdl/min_max_peak_pyramid_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max peak pyramid core
// Builds coarser min/max levels from a stream of base peak buckets.
// ----------------------------------------------------------------------------
// Each accepted word is loaded in the idle state, then stepped through every
// level it touches (the datapath reads and updates one level store per cycle
// while the result channel lets it), then the flush state hands its last
// result to the output register. The levels touched are the lowest one and
// each level a completed group climbs to, and on the last word of a run every
// active level. Words past the configured count, and all words when no level
// is active, produce nothing. A stalled result channel holds the walk whenever
// a word has a result to hand over while the output register still holds an
// earlier one. Writing the count starts a new run.
module min_max_peak_pyramid_core
   import mmpp_pkg::*;
#(
   parameter int RATIO          = RATIO_DEF,
   parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
   parameter int SMALLEST_LEVEL = SMALLEST_LEVEL_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [COUNT_W-1:0]         csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_bucket_low,
   input  wire logic signed [SAMPLE_W-1:0] req_bucket_high,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [LEVEL_W-1:0]              rsp_level,
   output logic [INDEX_W-1:0]              rsp_bucket_index,
   output logic signed [SAMPLE_W-1:0]      rsp_peak_low,
   output logic signed [SAMPLE_W-1:0]      rsp_peak_high,
   output logic                            rsp_level_end,
   output logic                            rsp_run_end
);

   localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   mmpp_cmd_type    cmd;
   mmpp_status_type status;
   logic [IDX_W-1:0] lvl;

   mmpp_ctrl #(
      .RATIO          (RATIO),
      .MAX_LEVELS     (MAX_LEVELS),
      .SMALLEST_LEVEL (SMALLEST_LEVEL)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .lvl         (lvl),
      .status      (status)
   );

   mmpp_datapath #(
      .RATIO      (RATIO),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .lvl              (lvl),
      .status           (status),
      .in_low           (req_bucket_low),
      .in_high          (req_bucket_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_peak_low     (rsp_peak_low),
      .rsp_peak_high    (rsp_peak_high),
      .rsp_level_end    (rsp_level_end),
      .rsp_run_end      (rsp_run_end)
   );

endmodule
`default_nettype wire
